>>> rtl/presentation_delay_tracker_assert.svh
`ifndef PRESENTATION_DELAY_TRACKER_ASSERT_SVH
`define PRESENTATION_DELAY_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pdt_pkg.sv
`default_nettype none

package pdt_pkg;

    // Field and datapath widths.
    localparam int TIME_W     = 48;
    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 18;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = 6;
    localparam int DIV_STEP   = 4;

    typedef logic [TIME_W-1:0]        tstamp_t;
    typedef logic signed [23:0]       sample_t;
    typedef logic signed [25:0]       elapsed_t;
    typedef logic signed [31:0]       delay_t;
    typedef logic signed [33:0]       err_t;
    typedef logic signed [43:0]       delta_t;
    typedef logic [23:0]              dev_t;
    typedef logic [25:0]              thr_t;
    typedef logic [GAIN_W-1:0]        gain_t;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START_ABOVE = 3'd0,
        CFG_START_BELOW = 3'd1,
        CFG_STOP        = 3'd2,
        CFG_RATE_UP     = 3'd3,
        CFG_RATE_DOWN   = 3'd4
    } cfg_index_t;

    // Register reset values (Q.16).
    localparam gain_t START_ABOVE_RST = 18'd7864;
    localparam gain_t START_BELOW_RST = 18'd78643;
    localparam gain_t STOP_RST        = 18'd39322;
    localparam gain_t RATE_UP_RST     = 18'd111411;
    localparam gain_t RATE_DOWN_RST   = 18'd21627;

    // Clamp limits in Q.16 seconds.
    localparam int ONE_Q16    = 65536;
    localparam int SAMPLE_MIN = -8388608;
    localparam int NEG_LIMIT  = -16777216;

    localparam delay_t DELAY_MAX = 32'sh7FFF_FFFF;
    localparam delay_t DELAY_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

>>> rtl/presentation_delay_tracker.sv
// A tick passes the window update, mean divide, deviation pass, deviation divide, error and
// factor states, and the delta and apply states when an adjustment runs, before m_tvalid; the
// radix-16 divider runs D = ceil((clog2(WINDOW) + 25) / 4) steps for the mean and deviation.
// A new item is taken only in the idle state, not while another is in flight; a pause item or a
// tick while paused goes from its own state straight to the output state.
// Reset clears the window, delay and last tick time, sets adjusting and loads the gains.
`default_nettype none
`include "presentation_delay_tracker_assert.svh"

module presentation_delay_tracker #(
    parameter int unsigned WINDOW = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pdt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pdt_pkg::GAIN_W-1:0]       cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pause_value, now_time[47:0], sim_time[47:0], zero pad (lowest bit first)
    input  logic [pdt_pkg::IN_DATA_W-1:0]    s_tdata,
    // kind
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // delay_out[31:0], adjusting_out, paused_out, zero pad (lowest bit first)
    output logic [pdt_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int LOG_W     = $clog2(WINDOW);
    localparam int AW        = (WINDOW > 1) ? LOG_W : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = pdt_pkg::SAMPLE_W + LOG_W + 1;
    localparam int DIV_ITERS = (SUM_W + pdt_pkg::DIV_STEP - 1) / pdt_pkg::DIV_STEP;
    localparam int DIV_W     = DIV_ITERS * pdt_pkg::DIV_STEP;
    localparam int DCNT_W    = $clog2(DIV_ITERS + 1);
    localparam int REM_W     = LOG_W + 2;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [SUM_W-1:0]        devsum_t;
    typedef logic signed [DIV_W-1:0] wide_t;
    typedef logic [DIV_W-1:0]        quo_t;
    typedef logic [REM_W-1:0]        rem_t;
    typedef logic [AW-1:0]           addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [DCNT_W-1:0]       dcnt_t;

    localparam addr_t WIN_LAST  = addr_t'(WINDOW - 1);
    localparam cnt_t  WIN_CNT   = cnt_t'(WINDOW);
    localparam rem_t  WIN_REM   = rem_t'(WINDOW);
    localparam quo_t  WIN_ROUND = quo_t'(WINDOW - 1);
    localparam dcnt_t DIV_LOAD  = dcnt_t'(DIV_ITERS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAUSE,
        ST_TICK,
        ST_OLD,
        ST_MEAN,
        ST_DEV,
        ST_DEVDIV,
        ST_ERR,
        ST_FACTOR,
        ST_DELTA,
        ST_APPLY,
        ST_OUT
    } state_t;

    // Control and architectural state.
    state_t                          state_reg, state_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    pdt_pkg::delay_t                 delay_reg, delay_next;
    logic                            adjusting_reg, adjusting_next;
    logic                            paused_reg, paused_next;
    pdt_pkg::tstamp_t                last_reg, last_next;
    logic [WINDOW-1:0]               valid_reg, valid_next;
    addr_t                           wp_reg, wp_next;
    sum_t                            sum_reg, sum_next;
    pdt_pkg::gain_t                  start_above_reg, start_above_next;
    pdt_pkg::gain_t                  start_below_reg, start_below_next;
    pdt_pkg::gain_t                  stop_reg, stop_next;
    pdt_pkg::gain_t                  rate_up_reg, rate_up_next;
    pdt_pkg::gain_t                  rate_down_reg, rate_down_next;
    dcnt_t                           div_cnt_reg, div_cnt_next;
    cnt_t                            pass_cnt_reg, pass_cnt_next;
    logic                            rd_valid_reg;

    // Working registers of the current item.
    logic                            pv_reg, pv_next;
    pdt_pkg::tstamp_t                now_reg, now_next;
    pdt_pkg::tstamp_t                sim_reg, sim_next;
    pdt_pkg::elapsed_t               elapsed_reg, elapsed_next;
    pdt_pkg::sample_t                sample_reg, sample_next;
    pdt_pkg::sample_t                mean_reg, mean_next;
    devsum_t                         devsum_reg, devsum_next;
    pdt_pkg::dev_t                   dev_reg, dev_next;
    pdt_pkg::err_t                   err_reg, err_next;
    pdt_pkg::thr_t                   thr_a_reg, thr_a_next;
    pdt_pkg::thr_t                   thr_b_reg, thr_b_next;
    pdt_pkg::thr_t                   thr_s_reg, thr_s_next;
    pdt_pkg::elapsed_t               factor_reg, factor_next;
    pdt_pkg::delta_t                 delta_reg, delta_next;
    rem_t                            div_rem_reg, div_rem_next;
    quo_t                            div_quo_reg, div_quo_next;
    logic                            div_neg_reg, div_neg_next;
    logic [pdt_pkg::OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // Window memory.
    pdt_pkg::sample_t                win_mem [WINDOW];
    pdt_pkg::sample_t                rd_data_reg;
    addr_t                           rd_addr;
    logic                            mem_we;

    // Datapath temporaries.
    logic signed [48:0]              el_diff;
    logic signed [48:0]              samp_diff;
    pdt_pkg::sample_t                old_val;
    sum_t                            sum_new;
    wide_t                           sum_wide;
    pdt_pkg::sample_t                cur_val;
    logic signed [25:0]              dev_diff;
    logic [24:0]                     abs_diff;
    devsum_t                         dev_acc;
    logic                            div_load;
    quo_t                            div_dividend;
    logic                            div_neg_in;
    rem_t                            step_rem;
    quo_t                            step_quo;
    logic [41:0]                     prod_a;
    logic [41:0]                     prod_b;
    logic [41:0]                     prod_s;
    pdt_pkg::err_t                   err_full;
    pdt_pkg::err_t                   thr_a_x;
    pdt_pkg::err_t                   thr_b_x;
    pdt_pkg::err_t                   thr_s_x;
    logic signed [18:0]              rate_s;
    logic signed [43:0]              prod_f;
    logic signed [27:0]              fq;
    logic                            adj_now;
    logic signed [59:0]              prod_d;
    logic signed [44:0]              nd;
    pdt_pkg::err_t                   aerr;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Clamped elapsed time and sample of a tick.
    assign el_diff   = $signed({1'b0, now_reg}) - $signed({1'b0, last_reg});
    assign samp_diff = $signed({1'b0, now_reg}) - $signed({1'b0, sim_reg});

    // Running sum update with the oldest entry replaced by the new sample.
    assign old_val  = rd_valid_reg ? rd_data_reg : '0;
    assign sum_new  = sum_reg - sum_t'(old_val) + sum_t'(sample_reg);
    assign sum_wide = wide_t'(sum_new);

    // Absolute deviation of the entry read in the previous cycle.
    assign cur_val  = rd_valid_reg ? rd_data_reg : '0;
    assign dev_diff = pdt_pkg::elapsed_t'(cur_val) - pdt_pkg::elapsed_t'(mean_reg);
    assign abs_diff = dev_diff[25] ? 25'(-dev_diff) : 25'(dev_diff);
    assign dev_acc  = devsum_reg + devsum_t'(abs_diff);

    // Threshold products of the deviation and the gains.
    assign prod_a   = 42'(dev_reg) * 42'(start_above_reg);
    assign prod_b   = 42'(dev_reg) * 42'(start_below_reg);
    assign prod_s   = 42'(dev_reg) * 42'(stop_reg);
    assign err_full = pdt_pkg::err_t'(mean_reg) + pdt_pkg::err_t'($signed({1'b0, dev_reg}))
                      - pdt_pkg::err_t'(delay_reg);

    // Hysteresis decision and step factor.
    assign thr_a_x = pdt_pkg::err_t'($signed({1'b0, thr_a_reg}));
    assign thr_b_x = pdt_pkg::err_t'($signed({1'b0, thr_b_reg}));
    assign thr_s_x = pdt_pkg::err_t'($signed({1'b0, thr_s_reg}));
    assign adj_now = adjusting_reg || (err_reg > thr_a_x) || (err_reg < -thr_b_x);
    assign rate_s  = $signed({1'b0, (err_reg > 0) ? rate_up_reg : rate_down_reg});
    assign prod_f  = rate_s * elapsed_reg;
    assign fq      = prod_f[43:16];

    // Delay step and saturation.
    assign prod_d = err_reg * factor_reg;
    assign nd     = 45'(delay_reg) + 45'(delta_reg);
    assign aerr   = err_reg[33] ? -err_reg : err_reg;

    // Memory read address: oldest entry for a tick, sweep index for the deviation pass.
    always_comb
    begin
        rd_addr = wp_reg;
        if (state_reg == ST_DEV)
        begin
            rd_addr = (pass_cnt_reg < WIN_CNT) ? pass_cnt_reg[AW-1:0] : '0;
        end
    end

    // Radix-16 restoring divide step by WINDOW.
    always_comb
    begin
        step_rem = div_rem_reg;
        step_quo = div_quo_reg;
        for (int k = 0; k < pdt_pkg::DIV_STEP; k++)
        begin
            step_rem = {step_rem[REM_W-2:0], step_quo[DIV_W-1]};
            step_quo = {step_quo[DIV_W-2:0], 1'b0};
            if (step_rem >= WIN_REM)
            begin
                step_rem    = step_rem - WIN_REM;
                step_quo[0] = 1'b1;
            end
        end
    end

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        delay_next       = delay_reg;
        adjusting_next   = adjusting_reg;
        paused_next      = paused_reg;
        last_next        = last_reg;
        valid_next       = valid_reg;
        wp_next          = wp_reg;
        sum_next         = sum_reg;
        start_above_next = start_above_reg;
        start_below_next = start_below_reg;
        stop_next        = stop_reg;
        rate_up_next     = rate_up_reg;
        rate_down_next   = rate_down_reg;
        pass_cnt_next    = pass_cnt_reg;
        pv_next          = pv_reg;
        now_next         = now_reg;
        sim_next         = sim_reg;
        elapsed_next     = elapsed_reg;
        sample_next      = sample_reg;
        mean_next        = mean_reg;
        devsum_next      = devsum_reg;
        dev_next         = dev_reg;
        err_next         = err_reg;
        thr_a_next       = thr_a_reg;
        thr_b_next       = thr_b_reg;
        thr_s_next       = thr_s_reg;
        factor_next      = factor_reg;
        delta_next       = delta_reg;
        m_tdata_next     = m_tdata_reg;
        mem_we           = 1'b0;
        div_load         = 1'b0;
        div_dividend     = '0;
        div_neg_in       = 1'b0;

        // Configuration writes are to arrive only while the block is idle; the block does not enforce it.
        if (cfg_we)
        begin
            case (cfg_addr)
                pdt_pkg::CFG_START_ABOVE: start_above_next = cfg_data;
                pdt_pkg::CFG_START_BELOW: start_below_next = cfg_data;
                pdt_pkg::CFG_STOP:        stop_next        = cfg_data;
                pdt_pkg::CFG_RATE_UP:     rate_up_next     = cfg_data;
                pdt_pkg::CFG_RATE_DOWN:   rate_down_next   = cfg_data;
                default:                  ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    pv_next    = s_tdata[0];
                    now_next   = s_tdata[48:1];
                    sim_next   = s_tdata[96:49];
                    state_next = s_tuser[0] ? ST_PAUSE : ST_TICK;
                end
            end

            ST_PAUSE:
            begin
                paused_next    = pv_reg;
                delay_next     = '0;
                valid_next     = '0;
                sum_next       = '0;
                adjusting_next = 1'b1;
                state_next     = ST_OUT;
            end

            ST_TICK:
            begin
                // The oldest entry is read here for the running sum.
                last_next = now_reg;
                if (el_diff > pdt_pkg::ONE_Q16)
                begin
                    elapsed_next = pdt_pkg::elapsed_t'(pdt_pkg::ONE_Q16);
                end
                else if (el_diff < pdt_pkg::NEG_LIMIT)
                begin
                    elapsed_next = pdt_pkg::elapsed_t'(pdt_pkg::NEG_LIMIT);
                end
                else
                begin
                    elapsed_next = pdt_pkg::elapsed_t'(el_diff);
                end
                if (samp_diff > pdt_pkg::ONE_Q16)
                begin
                    sample_next = pdt_pkg::sample_t'(pdt_pkg::ONE_Q16);
                end
                else if (samp_diff < pdt_pkg::SAMPLE_MIN)
                begin
                    sample_next = pdt_pkg::sample_t'(pdt_pkg::SAMPLE_MIN);
                end
                else
                begin
                    sample_next = pdt_pkg::sample_t'(samp_diff);
                end
                state_next = paused_reg ? ST_OUT : ST_OLD;
            end

            ST_OLD:
            begin
                // Replace the oldest entry and start the mean divide.
                mem_we             = 1'b1;
                valid_next[wp_reg] = 1'b1;
                wp_next            = (wp_reg == WIN_LAST) ? '0 : wp_reg + 1'b1;
                sum_next           = sum_new;
                div_load           = 1'b1;
                div_neg_in         = sum_new[SUM_W-1];
                div_dividend       = sum_new[SUM_W-1] ? quo_t'(-sum_wide) + WIN_ROUND
                                                      : quo_t'(sum_wide);
                state_next         = ST_MEAN;
            end

            ST_MEAN:
            begin
                if (div_cnt_reg == '0)
                begin
                    mean_next     = pdt_pkg::sample_t'(div_neg_reg ? quo_t'(0) - div_quo_reg
                                                                   : div_quo_reg);
                    devsum_next   = '0;
                    pass_cnt_next = '0;
                    state_next    = ST_DEV;
                end
            end

            ST_DEV:
            begin
                // One read per cycle; each entry is accumulated in the cycle after its read.
                if (pass_cnt_reg != '0)
                begin
                    devsum_next = dev_acc;
                end
                pass_cnt_next = pass_cnt_reg + 1'b1;
                if (pass_cnt_reg == WIN_CNT)
                begin
                    div_load     = 1'b1;
                    div_dividend = quo_t'(dev_acc);
                    state_next   = ST_DEVDIV;
                end
            end

            ST_DEVDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    dev_next   = pdt_pkg::dev_t'(div_quo_reg);
                    state_next = ST_ERR;
                end
            end

            ST_ERR:
            begin
                err_next   = err_full;
                thr_a_next = prod_a[41:16];
                thr_b_next = prod_b[41:16];
                thr_s_next = prod_s[41:16];
                state_next = ST_FACTOR;
            end

            ST_FACTOR:
            begin
                adjusting_next = adj_now;
                if (fq > pdt_pkg::ONE_Q16)
                begin
                    factor_next = pdt_pkg::elapsed_t'(pdt_pkg::ONE_Q16);
                end
                else if (fq < pdt_pkg::NEG_LIMIT)
                begin
                    factor_next = pdt_pkg::elapsed_t'(pdt_pkg::NEG_LIMIT);
                end
                else
                begin
                    factor_next = pdt_pkg::elapsed_t'(fq);
                end
                state_next = adj_now ? ST_DELTA : ST_OUT;
            end

            ST_DELTA:
            begin
                delta_next = prod_d[59:16];
                state_next = ST_APPLY;
            end

            ST_APPLY:
            begin
                if (nd > 45'(pdt_pkg::DELAY_MAX))
                begin
                    delay_next = pdt_pkg::DELAY_MAX;
                end
                else if (nd < 45'(pdt_pkg::DELAY_MIN))
                begin
                    delay_next = pdt_pkg::DELAY_MIN;
                end
                else
                begin
                    delay_next = pdt_pkg::delay_t'(nd);
                end
                // The stop test uses the error from before the step.
                if (aerr < thr_s_x)
                begin
                    adjusting_next = 1'b0;
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{pdt_pkg::OUT_PAD_W{1'b0}}, paused_reg, adjusting_reg,
                                     delay_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Divider register update.
    always_comb
    begin
        div_cnt_next = div_cnt_reg;
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_neg_next = div_neg_reg;
        if (div_load)
        begin
            div_cnt_next = DIV_LOAD;
            div_rem_next = '0;
            div_quo_next = div_dividend;
            div_neg_next = div_neg_in;
        end
        else if (div_cnt_reg != '0)
        begin
            div_cnt_next = div_cnt_reg - 1'b1;
            div_rem_next = step_rem;
            div_quo_next = step_quo;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            delay_reg       <= '0;
            adjusting_reg   <= 1'b1;
            paused_reg      <= 1'b0;
            last_reg        <= '0;
            valid_reg       <= '0;
            wp_reg          <= '0;
            sum_reg         <= '0;
            start_above_reg <= pdt_pkg::START_ABOVE_RST;
            start_below_reg <= pdt_pkg::START_BELOW_RST;
            stop_reg        <= pdt_pkg::STOP_RST;
            rate_up_reg     <= pdt_pkg::RATE_UP_RST;
            rate_down_reg   <= pdt_pkg::RATE_DOWN_RST;
            div_cnt_reg     <= '0;
            pass_cnt_reg    <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            delay_reg       <= delay_next;
            adjusting_reg   <= adjusting_next;
            paused_reg      <= paused_next;
            last_reg        <= last_next;
            valid_reg       <= valid_next;
            wp_reg          <= wp_next;
            sum_reg         <= sum_next;
            start_above_reg <= start_above_next;
            start_below_reg <= start_below_next;
            stop_reg        <= stop_next;
            rate_up_reg     <= rate_up_next;
            rate_down_reg   <= rate_down_next;
            div_cnt_reg     <= div_cnt_next;
            pass_cnt_reg    <= pass_cnt_next;
            rd_valid_reg    <= valid_reg[rd_addr];
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge clk)
    begin
        pv_reg      <= pv_next;
        now_reg     <= now_next;
        sim_reg     <= sim_next;
        elapsed_reg <= elapsed_next;
        sample_reg  <= sample_next;
        mean_reg    <= mean_next;
        devsum_reg  <= devsum_next;
        dev_reg     <= dev_next;
        err_reg     <= err_next;
        thr_a_reg   <= thr_a_next;
        thr_b_reg   <= thr_b_next;
        thr_s_reg   <= thr_s_next;
        factor_reg  <= factor_next;
        delta_reg   <= delta_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_neg_reg <= div_neg_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Window memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[wp_reg] <= sample_reg;
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    // Checks on the sequencer and the window bookkeeping.
    `PDT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "item accepted while another is in flight")
    `PDT_ASSERT_NEXT(a_pause_clears, state_reg == ST_PAUSE,
        valid_reg == '0 && sum_reg == '0 && delay_reg == '0 && adjusting_reg,
        "pause item did not clear the window and delay")
    `PDT_ASSERT_NOW(a_empty_sum, valid_reg == '0, sum_reg == '0,
        "running sum nonzero with an empty window")
    `PDT_ASSERT_NOW(a_div_done_at_pass, state_reg == ST_DEV, div_cnt_reg == '0,
        "deviation pass started before the mean divide finished")
    `PDT_ASSERT_NEXT(a_paused_tick, state_reg == ST_TICK && paused_reg,
        $stable(valid_reg) && $stable(sum_reg) && $stable(delay_reg),
        "tick while paused changed the window or delay")

endmodule

`default_nettype wire
